// ----- rtl/asl_pkg.sv -----
package asl_pkg;

    localparam int CmdW     = 2;
    localparam int AngleW   = 10;
    localparam int LevelW   = 16;
    localparam int SrvStepW = 9;
    localparam int SpdStepW = 15;
    localparam int PwmW     = 8;
    localparam int FlagW    = 2;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 15;

    // Command codes.
    localparam logic [CmdW-1:0] CMD_APPLY = 2'd0;
    localparam logic [CmdW-1:0] CMD_STOP  = 2'd1;
    localparam logic [CmdW-1:0] CMD_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_LEFT   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_RIGHT  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_CENTRE = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SRVSTP = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SPDSTP = 3'd4;

    // Reset values.
    localparam logic signed [AngleW-1:0] LEFT_RST   = 10'sd45;
    localparam logic signed [AngleW-1:0] RIGHT_RST  = 10'sd135;
    localparam logic signed [AngleW-1:0] CENTRE_RST = 10'sd90;
    localparam logic [SrvStepW-1:0]      SRVSTP_RST = 9'd5;
    localparam logic [SpdStepW-1:0]      SPDSTP_RST = 15'd205;

    // Full scale drive level, 1.0 in Q3.12.
    localparam logic signed [LevelW+1:0] LEVEL_ONE = 18'sd4096;

    localparam int FLAG_SERVO = 0;
    localparam int FLAG_MOTOR = 1;

    typedef struct packed {
        logic signed [AngleW-1:0] left_limit;
        logic signed [AngleW-1:0] right_limit;
        logic signed [AngleW-1:0] centre;
        logic [SrvStepW-1:0]      servo_step;
        logic [SpdStepW-1:0]      speed_step;
    } t_cfg;

    typedef struct packed {
        logic [CmdW-1:0]          cmd;
        logic signed [AngleW-1:0] servo_target;
        logic signed [LevelW-1:0] speed_target;
        logic                     stop_drive;
    } t_cmd_item;

    typedef struct packed {
        logic signed [AngleW-1:0] servo_position;
        logic signed [LevelW-1:0] drive_level;
        logic [PwmW-1:0]          pwm_duty;
        logic                     forward;
        logic [FlagW-1:0]         error_flags;
    } t_res_item;

    typedef struct packed {
        logic signed [AngleW-1:0] servo_angle;
        logic signed [LevelW-1:0] drive_level;
        logic [FlagW-1:0]         flags;
    } t_state;

endpackage

// ----- rtl/asl_cmd_if.sv -----
interface asl_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [asl_pkg::CmdW-1:0]             cmd;
    logic signed [asl_pkg::AngleW-1:0]    servo_target;
    logic signed [asl_pkg::LevelW-1:0]    speed_target;
    logic                                 stop_drive;

    modport source (output valid, cmd, servo_target, speed_target, stop_drive,
                    input ready);
    modport sink (input valid, cmd, servo_target, speed_target, stop_drive,
                  output ready);
endinterface

// ----- rtl/asl_res_if.sv -----
interface asl_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [asl_pkg::AngleW-1:0]    servo_position;
    logic signed [asl_pkg::LevelW-1:0]    drive_level;
    logic [asl_pkg::PwmW-1:0]             pwm_duty;
    logic                                 forward;
    logic [asl_pkg::FlagW-1:0]            error_flags;

    modport source (output valid, servo_position, drive_level, pwm_duty, forward,
                    error_flags, input ready);
    modport sink (input valid, servo_position, drive_level, pwm_duty, forward,
                  error_flags, output ready);
endinterface

// ----- rtl/asl_cfg_regs.sv -----
module asl_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [asl_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [asl_pkg::CfgDataW-1:0]     i_cfg_data,
    output asl_pkg::t_cfg                    o_cfg
);

    asl_pkg::t_cfg r_cfg;
    asl_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                asl_pkg::CFG_LEFT:   n_cfg.left_limit  = i_cfg_data[asl_pkg::AngleW-1:0];
                asl_pkg::CFG_RIGHT:  n_cfg.right_limit = i_cfg_data[asl_pkg::AngleW-1:0];
                asl_pkg::CFG_CENTRE: n_cfg.centre      = i_cfg_data[asl_pkg::AngleW-1:0];
                asl_pkg::CFG_SRVSTP: n_cfg.servo_step  = i_cfg_data[asl_pkg::SrvStepW-1:0];
                asl_pkg::CFG_SPDSTP: n_cfg.speed_step  = i_cfg_data[asl_pkg::SpdStepW-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_limit  <= asl_pkg::LEFT_RST;
            r_cfg.right_limit <= asl_pkg::RIGHT_RST;
            r_cfg.centre      <= asl_pkg::CENTRE_RST;
            r_cfg.servo_step  <= asl_pkg::SRVSTP_RST;
            r_cfg.speed_step  <= asl_pkg::SPDSTP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/asl_step.sv -----
module asl_step (
    input  asl_pkg::t_cfg       i_cfg,
    input  asl_pkg::t_state     i_state,
    input  asl_pkg::t_cmd_item  i_item,
    output asl_pkg::t_state     o_state,
    output asl_pkg::t_res_item  o_res
);

    logic signed [asl_pkg::AngleW-1:0]   tgt_clamped;
    logic                                tgt_low;
    logic                                tgt_high;
    logic signed [asl_pkg::AngleW+1:0]   srv_now;
    logic signed [asl_pkg::AngleW+1:0]   srv_tgt;
    logic signed [asl_pkg::AngleW+1:0]   srv_up;
    logic signed [asl_pkg::AngleW+1:0]   srv_dn;
    logic signed [asl_pkg::AngleW-1:0]   srv_next;
    logic signed [asl_pkg::LevelW+1:0]   lvl_now;
    logic signed [asl_pkg::LevelW+1:0]   lvl_tgt;
    logic signed [asl_pkg::LevelW+1:0]   lvl_up;
    logic signed [asl_pkg::LevelW+1:0]   lvl_dn;
    logic signed [asl_pkg::LevelW+1:0]   lvl_ramp;
    logic signed [asl_pkg::LevelW-1:0]   lvl_next;
    logic                                motor_over;
    logic [asl_pkg::LevelW:0]            mag;
    logic [12:0]                         mag_sat;
    logic [20:0]                         duty_prod;
    logic [asl_pkg::FlagW-1:0]           flags_shown;

    // Target clamp: below left takes the left limit, without a second check.
    always_comb begin
        tgt_low  = i_item.servo_target < i_cfg.left_limit;
        tgt_high = i_item.servo_target > i_cfg.right_limit;
        if (tgt_low) begin
            tgt_clamped = i_cfg.left_limit;
        end else if (tgt_high) begin
            tgt_clamped = i_cfg.right_limit;
        end else begin
            tgt_clamped = i_item.servo_target;
        end
    end

    always_comb begin
        srv_now = {{2{i_state.servo_angle[asl_pkg::AngleW-1]}}, i_state.servo_angle};
        srv_tgt = {{2{tgt_clamped[asl_pkg::AngleW-1]}}, tgt_clamped};
        srv_up  = srv_now + $signed({3'b000, i_cfg.servo_step});
        srv_dn  = srv_now - $signed({3'b000, i_cfg.servo_step});
        if (srv_tgt > srv_up) begin
            srv_next = srv_up[asl_pkg::AngleW-1:0];
        end else if (srv_tgt < srv_dn) begin
            srv_next = srv_dn[asl_pkg::AngleW-1:0];
        end else begin
            srv_next = tgt_clamped;
        end
    end

    always_comb begin
        lvl_now = {{2{i_state.drive_level[asl_pkg::LevelW-1]}}, i_state.drive_level};
        if (i_item.stop_drive) begin
            lvl_tgt = '0;
        end else begin
            lvl_tgt = {{2{i_item.speed_target[asl_pkg::LevelW-1]}}, i_item.speed_target};
        end
        lvl_up = lvl_now + $signed({3'b000, i_cfg.speed_step});
        lvl_dn = lvl_now - $signed({3'b000, i_cfg.speed_step});
        if (lvl_tgt > lvl_up) begin
            lvl_ramp = lvl_up;
        end else if (lvl_tgt < lvl_dn) begin
            lvl_ramp = lvl_dn;
        end else begin
            lvl_ramp = lvl_tgt;
        end
        motor_over = (lvl_ramp > asl_pkg::LEVEL_ONE) || (lvl_ramp < -asl_pkg::LEVEL_ONE);
    end

    always_comb begin
        o_state     = i_state;
        flags_shown = i_state.flags;
        case (i_item.cmd)
            asl_pkg::CMD_APPLY: begin
                o_state.servo_angle = srv_next;
                o_state.drive_level = lvl_ramp[asl_pkg::LevelW-1:0];
                o_state.flags[asl_pkg::FLAG_SERVO] =
                    i_state.flags[asl_pkg::FLAG_SERVO] | tgt_low | tgt_high;
                o_state.flags[asl_pkg::FLAG_MOTOR] =
                    i_state.flags[asl_pkg::FLAG_MOTOR] | motor_over;
                flags_shown = o_state.flags;
            end
            asl_pkg::CMD_STOP: begin
                o_state.servo_angle = i_cfg.centre;
                o_state.drive_level = '0;
            end
            asl_pkg::CMD_READ: begin
                o_state.flags = '0;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    // Duty is min(|level|, 1.0) * 255 / 4096, with the multiply as shift and subtract.
    always_comb begin
        lvl_next = o_state.drive_level;
        if (lvl_next[asl_pkg::LevelW-1]) begin
            mag = (~{1'b1, lvl_next}) + 17'd1;
        end else begin
            mag = {1'b0, lvl_next};
        end
        if (mag > 17'd4096) begin
            mag_sat = 13'd4096;
        end else begin
            mag_sat = mag[12:0];
        end
        duty_prod = {mag_sat, 8'd0} - {8'd0, mag_sat};
    end

    assign o_res.servo_position = o_state.servo_angle;
    assign o_res.drive_level    = lvl_next;
    assign o_res.pwm_duty       = duty_prod[19:12];
    assign o_res.forward        = ~lvl_next[asl_pkg::LevelW-1];
    assign o_res.error_flags    = flags_shown;

endmodule

// ----- rtl/actuator_slew_limiter.sv -----
// Actuator slew limiter for one steering servo and one drive motor.
// Requests arrive on i_cmd (valid/ready) carrying a command: apply, stop or
// read-and-clear flags. Every request produces exactly one result on o_res
// with the servo position, the drive level, an 8-bit PWM duty, the
// direction bit and the sticky error flags.
// A request is captured in an input register on the edge it is accepted, and
// its result is loaded from there into the output register once that register
// is empty or being taken, and is offered to the receiver from there.
// The state update is a single clamp, add and compare per command, so one
// request per clock is sustained while the receiver takes every result.
// When the receiver stalls, the result holds in the output register, one more
// request is held in the input register, and i_cmd.ready then drops.
// Reset sets the limit registers to their defaults, the servo to the default
// centre, the drive level and flags to zero, and empties both registers.
// The configuration port writes one register per enabled edge; write it
// only while no request is in flight.
module actuator_slew_limiter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [asl_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [asl_pkg::CfgDataW-1:0]     i_cfg_data,
    asl_cmd_if.sink                          i_cmd,
    asl_res_if.source                        o_res
);

    asl_pkg::t_cfg      cfg;
    asl_pkg::t_cmd_item in_item;
    asl_pkg::t_state    n_state;
    asl_pkg::t_res_item n_res;

    logic               r_in_valid;
    asl_pkg::t_cmd_item r_in;
    logic               r_out_valid;
    asl_pkg::t_res_item r_out;
    asl_pkg::t_state    r_state;

    logic               out_adv;
    logic               in_adv;

    asl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    asl_step u_step (
        .i_cfg   (cfg),
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_res   (n_res)
    );

    assign out_adv = !r_out_valid || o_res.ready;
    assign in_adv  = !r_in_valid || out_adv;

    assign in_item.cmd          = i_cmd.cmd;
    assign in_item.servo_target = i_cmd.servo_target;
    assign in_item.speed_target = i_cmd.speed_target;
    assign in_item.stop_drive   = i_cmd.stop_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_state.servo_angle <= asl_pkg::CENTRE_RST;
            r_state.drive_level <= '0;
            r_state.flags       <= '0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_cmd.valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_in <= in_item;
        end
        if (out_adv && r_in_valid) begin
            r_out <= n_res;
        end
    end

    assign i_cmd.ready          = in_adv;
    assign o_res.valid          = r_out_valid;
    assign o_res.servo_position = r_out.servo_position;
    assign o_res.drive_level    = r_out.drive_level;
    assign o_res.pwm_duty       = r_out.pwm_duty;
    assign o_res.forward        = r_out.forward;
    assign o_res.error_flags    = r_out.error_flags;

endmodule

// ----- test/asl_result_checker.sv -----
module asl_result_checker
    import asl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    asl_cmd_if                  i_cmd,
    asl_res_if                  i_res,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FullScale = int'(LEVEL_ONE);
    localparam int PrintCap  = 40;

    t_cfg             lim;
    int               angle_now;
    int               level_now;
    logic [FlagW-1:0] sticky;
    t_res_item        due_q[$];
    t_res_item        got;
    t_res_item        want;
    int               fails   = 0;
    int               checked = 0;
    int               pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;
    assign o_checked    = checked;

    task automatic report_mismatch(input string what);
        fails++;
        if (fails <= PrintCap) begin
            $display("%0t asl_result_checker: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got_v,
                               input logic signed [31:0] want_v);
        if (got_v !== want_v) begin
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      checked, name, got_v, want_v));
        end
    endtask

    // Move toward the target by at most one step; never overshoots.
    function automatic int slew(input int now, input int target, input int step);
        if (target > now + step) return now + step;
        if (target < now - step) return now - step;
        return target;
    endfunction

    // Updates the actuator state for one request and returns what the block must report.
    function automatic t_res_item step_actuators(input logic [CmdW-1:0] op, input int tgt,
                                                 input int spd, input bit hold_drive);
        int               lo;
        int               hi;
        int               mag;
        logic [FlagW-1:0] shown;
        t_res_item        r;
        lo = $signed(lim.left_limit);
        hi = $signed(lim.right_limit);
        case (op)
            CMD_APPLY: begin
                if (tgt < lo || tgt > hi) sticky[FLAG_SERVO] = 1'b1;
                // With crossed limits a target below the left limit takes the left
                // limit and is not checked against the right one.
                if (tgt < lo) tgt = lo;
                else if (tgt > hi) tgt = hi;
                angle_now = slew(angle_now, tgt, int'(lim.servo_step));
                level_now = slew(level_now, hold_drive ? 0 : spd, int'(lim.speed_step));
                if (level_now > FullScale || level_now < -FullScale) sticky[FLAG_MOTOR] = 1'b1;
                shown = sticky;
            end
            CMD_STOP: begin
                angle_now = $signed(lim.centre);
                level_now = 0;
                shown     = sticky;
            end
            CMD_READ: begin
                shown  = sticky;
                sticky = '0;
            end
            default: begin
                shown = sticky;
            end
        endcase
        mag = (level_now < 0) ? -level_now : level_now;
        if (mag > FullScale) mag = FullScale;
        r.servo_position = AngleW'(angle_now);
        r.drive_level    = LevelW'(level_now);
        r.pwm_duty       = PwmW'(mag * 255 / FullScale);
        r.forward        = (level_now >= 0);
        r.error_flags    = shown;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lim.left_limit  = LEFT_RST;
            lim.right_limit = RIGHT_RST;
            lim.centre      = CENTRE_RST;
            lim.servo_step  = SRVSTP_RST;
            lim.speed_step  = SPDSTP_RST;
            angle_now       = $signed(CENTRE_RST);
            level_now       = 0;
            sticky          = '0;
            due_q.delete();
            pending         = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.servo_position = i_res.servo_position;
                got.drive_level    = i_res.drive_level;
                got.pwm_duty       = i_res.pwm_duty;
                got.forward        = i_res.forward;
                got.error_flags    = i_res.error_flags;
                if (due_q.size() == 0) begin
                    report_mismatch("result arrived with no request waiting for it");
                end else begin
                    want = due_q.pop_front();
                    check_field("servo_position", $signed(got.servo_position),
                                $signed(want.servo_position));
                    check_field("drive_level", $signed(got.drive_level),
                                $signed(want.drive_level));
                    check_field("pwm_duty", got.pwm_duty, want.pwm_duty);
                    check_field("forward", got.forward, want.forward);
                    check_field("error_flags", got.error_flags, want.error_flags);
                end
                checked++;
            end
            if (i_cmd.valid && i_cmd.ready) begin
                due_q.push_back(step_actuators(i_cmd.cmd, $signed(i_cmd.servo_target),
                                               $signed(i_cmd.speed_target),
                                               i_cmd.stop_drive));
            end
            // A register write lands after any request taken on the same edge.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LEFT:   lim.left_limit  = i_cfg_data[AngleW-1:0];
                    CFG_RIGHT:  lim.right_limit = i_cfg_data[AngleW-1:0];
                    CFG_CENTRE: lim.centre      = i_cfg_data[AngleW-1:0];
                    CFG_SRVSTP: lim.servo_step  = i_cfg_data[SrvStepW-1:0];
                    CFG_SPDSTP: lim.speed_step  = i_cfg_data[SpdStepW-1:0];
                    default: ;
                endcase
            end
            pending = due_q.size();
        end
    end

endmodule

// ----- test/actuator_slew_limiter_tb.sv -----
module actuator_slew_limiter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asl_pkg::*;

    localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
    localparam int QuietLimit  = 1000;
    localparam int PhaseItems  = 240;
    localparam int TailCycles  = 12;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    int fail_count;
    int pending;
    int checked;

    bit calm;
    int lim_left;
    int lim_right;
    int n_settings;
    int n_by_cmd [4];

    asl_cmd_if cmd_bus ();
    asl_res_if res_bus ();

    actuator_slew_limiter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_cmd       (cmd_bus),
        .o_res       (res_bus)
    );

    asl_result_checker result_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_cmd        (cmd_bus),
        .i_res        (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int tx_gap();
        if ($urandom_range(0, 99) < 55) return 0;
        return idle_len();
    endfunction

    task automatic send_cmd(input logic [CmdW-1:0] op, input int tgt, input int spd,
                            input bit hold_drive);
        int gap;
        gap = calm ? 0 : tx_gap();
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.cmd          <= op;
        cmd_bus.servo_target <= AngleW'(tgt);
        cmd_bus.speed_target <= LevelW'(spd);
        cmd_bus.stop_drive   <= hold_drive;
        do @(posedge i_clk); while (!cmd_bus.ready);
        n_by_cmd[op]++;
    endtask

    // Stop sending and wait until every request has its result back.
    task automatic drain_requests();
        cmd_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CfgDataW'(value);
    endtask

    task automatic set_limits(input int left, input int right, input int centre,
                              input int servo_step, input int speed_step);
        drain_requests();
        write_reg(CFG_LEFT, left);
        write_reg(CFG_RIGHT, right);
        write_reg(CFG_CENTRE, centre);
        write_reg(CFG_SRVSTP, servo_step);
        write_reg(CFG_SPDSTP, speed_step);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        lim_left  = left;
        lim_right = right;
        n_settings++;
    endtask

    task automatic random_cmd();
        int              r;
        int              lo;
        int              hi;
        int              tgt;
        int              spd;
        logic [CmdW-1:0] op;
        r = $urandom_range(0, 99);
        if (r < 72) op = CMD_APPLY;
        else if (r < 82) op = CMD_STOP;
        else if (r < 95) op = CMD_READ;
        else op = CMD_UNUSED;
        // Half the targets land near the limit window so clamping edges get hit.
        lo = ((lim_left < lim_right) ? lim_left : lim_right) - 12;
        hi = ((lim_left > lim_right) ? lim_left : lim_right) + 12;
        if (lo < -512) lo = -512;
        if (hi > 511) hi = 511;
        if ($urandom_range(0, 1) == 1) tgt = lo + int'($urandom_range(0, hi - lo));
        else tgt = int'($urandom_range(0, 1023)) - 512;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            spd = int'($urandom_range(0, 65535)) - 32768;
        end else if (r < 8) begin
            spd = int'($urandom_range(0, 12000)) - 6000;
        end else begin
            case ($urandom_range(0, 5))
                0: spd = -32768;
                1: spd = 32767;
                2: spd = 4096;
                3: spd = -4096;
                4: spd = 4097;
                default: spd = -4097;
            endcase
        end
        send_cmd(op, tgt, spd, $urandom_range(0, 4) == 0);
    endtask

    initial begin : result_sink
        int hold_left;
        bit take;
        hold_left = 0;
        take      = 1'b1;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0) begin
                if (calm || $urandom_range(0, 2) != 0) begin
                    take      = 1'b1;
                    hold_left = $urandom_range(1, 12);
                end else begin
                    take      = 1'b0;
                    hold_left = idle_len();
                end
            end
            res_bus.ready <= take;
            hold_left--;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge i_clk);
            if (!i_rst_n || (cmd_bus.valid && cmd_bus.ready) ||
                (res_bus.valid && res_bus.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("actuator_slew_limiter_tb: nothing moved for %0d cycles", QuietLimit);
        $display("actuator_slew_limiter_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_LEFT;
        cfg_data             <= '0;
        cmd_bus.valid        <= 1'b0;
        cmd_bus.cmd          <= CMD_APPLY;
        cmd_bus.servo_target <= '0;
        cmd_bus.speed_target <= '0;
        cmd_bus.stop_drive   <= 1'b0;
        calm       = 1'b0;
        lim_left   = $signed(LEFT_RST);
        lim_right  = $signed(RIGHT_RST);
        n_settings = 1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default limits: flags from reset, out-of-range targets, read and clear.
        send_cmd(CMD_READ, 0, 0, 1'b0);
        send_cmd(CMD_UNUSED, 0, 0, 1'b0);
        send_cmd(CMD_APPLY, 511, 32767, 1'b0);
        send_cmd(CMD_APPLY, -512, -32768, 1'b1);
        send_cmd(CMD_APPLY, 90, 4096, 1'b0);
        send_cmd(CMD_READ, 0, 0, 1'b0);
        send_cmd(CMD_READ, 0, 0, 1'b0);
        send_cmd(CMD_STOP, 0, 0, 1'b0);
        send_cmd(CMD_APPLY, 45, 0, 1'b0);
        send_cmd(CMD_APPLY, 135, -4096, 1'b0);
        send_cmd(CMD_READ, 0, 0, 1'b0);

        // Widest window and largest steps: drive level swings past full scale.
        set_limits(-512, 511, -512, 511, 32767);
        send_cmd(CMD_APPLY, 511, 32767, 1'b0);
        send_cmd(CMD_APPLY, -512, -32768, 1'b0);
        send_cmd(CMD_APPLY, -512, -32768, 1'b0);
        send_cmd(CMD_APPLY, -512, -32768, 1'b0);
        send_cmd(CMD_UNUSED, 7, 7, 1'b1);
        send_cmd(CMD_STOP, 0, 0, 1'b0);
        send_cmd(CMD_READ, 0, 0, 1'b0);

        // Crossed limits and zero steps: nothing ramps, every apply flags.
        set_limits(100, -100, 511, 0, 0);
        send_cmd(CMD_APPLY, 0, 1000, 1'b0);
        send_cmd(CMD_APPLY, 300, -1000, 1'b0);
        send_cmd(CMD_STOP, 0, 0, 1'b0);
        send_cmd(CMD_READ, 0, 0, 1'b0);
        send_cmd(CMD_APPLY, -100, 2000, 1'b1);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_limits($signed(LEFT_RST), $signed(RIGHT_RST), $signed(CENTRE_RST),
                              SRVSTP_RST, SPDSTP_RST);
                1: set_limits(-int'($urandom_range(0, 200)), $urandom_range(1, 200),
                              int'($urandom_range(0, 100)) - 50, $urandom_range(1, 20),
                              $urandom_range(50, 2000));
                2: set_limits(-512, 511, 511, 511, 32767);
                3: set_limits(511, -512, -512, 0, 0);
                4: set_limits(int'($urandom_range(0, 1023)) - 512,
                              int'($urandom_range(0, 1023)) - 512,
                              int'($urandom_range(0, 1023)) - 512,
                              $urandom_range(0, 511), $urandom_range(0, 32767));
                default: set_limits(-int'($urandom_range(20, 300)), $urandom_range(20, 300),
                                    0, $urandom_range(1, 60), $urandom_range(3000, 9000));
            endcase
            // One phase runs flat out on both sides.
            calm = (ph == 2);
            repeat (PhaseItems) random_cmd();
        end
        calm = 1'b0;

        drain_requests();
        repeat (TailCycles) @(posedge i_clk);
        $display("actuator_slew_limiter_tb: %0d requests (apply %0d, stop %0d, read %0d, code 3 %0d)",
                 n_by_cmd[0] + n_by_cmd[1] + n_by_cmd[2] + n_by_cmd[3],
                 n_by_cmd[CMD_APPLY], n_by_cmd[CMD_STOP], n_by_cmd[CMD_READ],
                 n_by_cmd[CMD_UNUSED]);
        $display("actuator_slew_limiter_tb: %0d results compared across %0d limit settings",
                 checked, n_settings);
        if (fail_count == 0 && pending == 0) begin
            $display("actuator_slew_limiter_tb: done, clean");
        end else begin
            $display("actuator_slew_limiter_tb: done, errors");
        end
        $finish;
    end

endmodule
